@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the motor command parser
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: invariant");

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next cycle");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ src/amcp_pkg.sv @@
// ----------------------------------------------------------------------------
// amcp_pkg
// types, constants and keyword table of the ascii motor command parser
// ----------------------------------------------------------------------------
package amcp_pkg;

    localparam int LINE_BYTES_DEF = 64;

    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;
    localparam int FSV_W  = 10;
    localparam int ACC_W  = 17;
    localparam int PROD_W = 18;
    localparam int VEL_W  = 15;

    localparam logic [ADDR_W-3:0] REG_FULL_SCALE = 1'b0;
    localparam logic [FSV_W-1:0]  FSV_RESET      = 10'd500;

    localparam logic [1:0] KIND_PING  = 2'd0;
    localparam logic [1:0] KIND_STOP  = 2'd1;
    localparam logic [1:0] KIND_MOTOR = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    localparam logic [ACC_W-1:0] ACC_CAP   = 17'd131071;
    localparam logic [7:0]       SPEED_MAX = 8'd255;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_COMMA = 8'd44;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_LT    = 8'd60;

    // keyword rows: PING, ping, STOP, stop
    localparam logic [7:0] KW_TEXT [4][4] = '{
        '{8'h50, 8'h49, 8'h4E, 8'h47},
        '{8'h70, 8'h69, 8'h6E, 8'h67},
        '{8'h53, 8'h54, 8'h4F, 8'h50},
        '{8'h73, 8'h74, 8'h6F, 8'h70}
    };

    typedef enum logic [3:0] {
        PH_START   = 4'd0,
        PH_N0_LEAD = 4'd1,
        PH_N0_SIGN = 4'd2,
        PH_N0_DIG  = 4'd3,
        PH_N1_LEAD = 4'd4,
        PH_N1_SIGN = 4'd5,
        PH_N1_DIG  = 4'd6,
        PH_N2_LEAD = 4'd7,
        PH_N2_SIGN = 4'd8,
        PH_N2_DIG  = 4'd9,
        PH_DONE    = 4'd10,
        PH_FAIL    = 4'd11
    } phase_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       motor;
        logic       fwd;
        logic [7:0] speed;
    } cmd_t;

endpackage

@@ src/amcp_parser.sv @@
// ----------------------------------------------------------------------------
// amcp_parser
// line state and per-byte parsing; flags a command at the end of a line
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module amcp_parser #(
    parameter int LINE_BYTES = amcp_pkg::LINE_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             strobe,
    input  logic [7:0]       rx_byte,
    output logic             emit,
    output amcp_pkg::cmd_t   cmd
);
    import amcp_pkg::*;

    localparam int LEN_W = $clog2(LINE_BYTES);
    localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(LINE_BYTES - 1);
    localparam logic [LEN_W-1:0] LEN_FOUR = LEN_W'(4);

    logic [LEN_W-1:0] line_length_reg, line_length_next;
    phase_t           phase_reg, phase_next;
    logic [3:0]       keyword_match_reg, keyword_match_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic             negative_reg, negative_next;
    logic             motor_reg, motor_next;
    logic             direction_reg, direction_next;
    logic             zero_seen_reg, zero_seen_next;

    logic             is_term;
    logic             is_blank;
    logic             is_digit;
    logic [3:0]       digit;
    logic [ACC_W+3:0] acc_grow;
    logic             positive;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg   <= '0;
            phase_reg         <= PH_START;
            keyword_match_reg <= 4'hF;
            acc_reg           <= '0;
            negative_reg      <= 1'b0;
            motor_reg         <= 1'b0;
            direction_reg     <= 1'b0;
            zero_seen_reg     <= 1'b0;
        end
        else
        begin
            line_length_reg   <= line_length_next;
            phase_reg         <= phase_next;
            keyword_match_reg <= keyword_match_next;
            acc_reg           <= acc_next;
            negative_reg      <= negative_next;
            motor_reg         <= motor_next;
            direction_reg     <= direction_next;
            zero_seen_reg     <= zero_seen_next;
        end
    end

    assign is_term  = (rx_byte == CH_LF) || (rx_byte == CH_CR);
    assign is_blank = (rx_byte == CH_TAB) || (rx_byte == CH_VT) ||
                      (rx_byte == CH_FF) || (rx_byte == CH_SPACE);
    assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign digit    = rx_byte[3:0];
    assign acc_grow = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} +
                      (ACC_W+4)'(digit);
    assign positive = !negative_reg && (acc_reg != '0);

    always_comb
    begin
        line_length_next   = line_length_reg;
        phase_next         = phase_reg;
        keyword_match_next = keyword_match_reg;
        acc_next           = acc_reg;
        negative_next      = negative_reg;
        motor_next         = motor_reg;
        direction_next     = direction_reg;
        zero_seen_next     = zero_seen_reg;
        emit               = 1'b0;
        cmd                = '0;

        // end of line decision from the state before the terminator
        if ((line_length_reg >= LEN_FOUR) && (keyword_match_reg[1:0] != 2'b00))
        begin
            cmd.kind = KIND_PING;
            emit     = 1'b1;
        end
        else if ((line_length_reg >= LEN_FOUR) && (keyword_match_reg[3:2] != 2'b00))
        begin
            cmd.kind = KIND_STOP;
            emit     = 1'b1;
        end
        else if ((phase_reg == PH_DONE) || (phase_reg == PH_N2_DIG))
        begin
            cmd.kind  = KIND_MOTOR;
            cmd.motor = motor_reg;
            cmd.fwd   = direction_reg;
            if (negative_reg)
            begin
                cmd.speed = 8'd0;
            end
            else if (acc_reg > ACC_W'(SPEED_MAX))
            begin
                cmd.speed = SPEED_MAX;
            end
            else
            begin
                cmd.speed = acc_reg[7:0];
            end
            emit = 1'b1;
        end
        if (!(strobe && is_term && (line_length_reg != '0)))
        begin
            emit = 1'b0;
        end

        if (strobe)
        begin
            if (is_term || (line_length_reg >= LEN_MAX))
            begin
                // empty line keeps the state as it is, which is already clear
                if (is_term && (line_length_reg == '0))
                begin
                    line_length_next = line_length_reg;
                end
                else
                begin
                    line_length_next   = '0;
                    phase_next         = PH_START;
                    keyword_match_next = 4'hF;
                    acc_next           = '0;
                    negative_next      = 1'b0;
                    zero_seen_next     = 1'b0;
                end
            end
            else
            begin
                line_length_next = line_length_reg + LEN_W'(1);
                if (!zero_seen_reg)
                begin
                    if (rx_byte == CH_NUL)
                    begin
                        zero_seen_next = 1'b1;
                        if (line_length_reg < LEN_FOUR)
                        begin
                            keyword_match_next = 4'h0;
                        end
                    end
                    else
                    begin
                        // keyword tracking
                        if (line_length_reg < LEN_FOUR)
                        begin
                            for (int i = 0; i < 4; i++)
                            begin
                                if (rx_byte != KW_TEXT[i][line_length_reg[1:0]])
                                begin
                                    keyword_match_next[i] = 1'b0;
                                end
                            end
                        end
                        else
                        begin
                            keyword_match_next = 4'h0;
                        end

                        // number scanning
                        case (phase_reg)
                            PH_START:
                            begin
                                phase_next = (rx_byte == CH_LT) ? PH_N0_LEAD : PH_FAIL;
                            end
                            PH_N0_LEAD, PH_N1_LEAD, PH_N2_LEAD:
                            begin
                                if (is_blank)
                                begin
                                    phase_next = phase_reg;
                                end
                                else if ((rx_byte == CH_PLUS) || (rx_byte == CH_MINUS))
                                begin
                                    negative_next = (rx_byte == CH_MINUS);
                                    acc_next      = '0;
                                    phase_next    = phase_t'(phase_reg + 4'd1);
                                end
                                else if (is_digit)
                                begin
                                    negative_next = 1'b0;
                                    acc_next      = ACC_W'(digit);
                                    phase_next    = phase_t'(phase_reg + 4'd2);
                                end
                                else
                                begin
                                    phase_next = PH_FAIL;
                                end
                            end
                            PH_N0_SIGN, PH_N1_SIGN, PH_N2_SIGN:
                            begin
                                if (is_digit)
                                begin
                                    acc_next   = ACC_W'(digit);
                                    phase_next = phase_t'(phase_reg + 4'd1);
                                end
                                else
                                begin
                                    phase_next = PH_FAIL;
                                end
                            end
                            PH_N0_DIG, PH_N1_DIG, PH_N2_DIG:
                            begin
                                if (is_digit)
                                begin
                                    acc_next = (acc_grow > (ACC_W+4)'(ACC_CAP)) ?
                                               ACC_CAP : acc_grow[ACC_W-1:0];
                                end
                                else if (phase_reg == PH_N2_DIG)
                                begin
                                    phase_next = PH_DONE;
                                end
                                else if (rx_byte == CH_COMMA)
                                begin
                                    if (phase_reg == PH_N0_DIG)
                                    begin
                                        motor_next = positive;
                                    end
                                    else
                                    begin
                                        direction_next = positive;
                                    end
                                    phase_next = phase_t'(phase_reg + 4'd1);
                                end
                                else
                                begin
                                    phase_next = PH_FAIL;
                                end
                            end
                            default:
                            begin
                                phase_next = phase_reg;
                            end
                        endcase
                    end
                end
            end
        end
    end

    `ASSERT_ALWAYS(a_len_bound, clk, rst_n, line_length_reg <= LEN_MAX)
    `ASSERT_IMPLIES(a_zero_len, clk, rst_n, zero_seen_reg, line_length_reg != '0)
    `ASSERT_IMPLIES(a_kw_fail, clk, rst_n,
        (keyword_match_reg != 4'h0) && (line_length_reg != '0), phase_reg == PH_FAIL)

endmodule

@@ src/amcp_scale.sv @@
// ----------------------------------------------------------------------------
// amcp_scale
// speed * full scale * 16 / 255, rounded to nearest, signed by direction
// ----------------------------------------------------------------------------
module amcp_scale (
    input  amcp_pkg::cmd_t                  cmd,
    input  logic [amcp_pkg::PROD_W-1:0]     product,
    output logic signed [amcp_pkg::VEL_W-1:0] velocity
);
    import amcp_pkg::*;

    localparam int X_W = PROD_W + 4;

    logic [X_W-1:0]   x;
    logic [X_W:0]     t;
    logic [VEL_W-1:0] q_est;
    logic [X_W:0]     rem;
    logic [VEL_W-1:0] mag;

    // x/255 estimated as x*(1 + 2^-8 + 2^-16)/256, low by at most one
    assign x     = {product, 4'b0000} + X_W'(127);
    assign t     = {1'b0, x} + (X_W+1)'(x >> 8) + (X_W+1)'(x >> 16);
    assign q_est = t[X_W:8];
    assign rem   = {1'b0, x} - {q_est, 8'h00} + (X_W+1)'(q_est);
    assign mag   = q_est + VEL_W'(rem >= (X_W+1)'(255));

    assign velocity = cmd.fwd ? signed'(mag) : signed'(VEL_W'(-mag));

endmodule

@@ src/ascii_motor_command_parser.sv @@
// ----------------------------------------------------------------------------
// ascii_motor_command_parser
// assembles received bytes into lines and emits ping, stop and motor commands
//
//   channel  | signals                               | dir
//   ---------+---------------------------------------+-----
//   rx       | in_valid, in_ready, rx_byte           | in
//   command  | out_valid, out_ready, command_kind,   | out
//            | motor_select, forward, speed_level,   |
//            | velocity                              |
//   config   | psel, penable, pwrite, paddr, pwdata, | in
//            | prdata, pready                        |
//
// one byte transfer per cycle sustained while no stall backs up the stages; a line
// terminator is held in the byte register, then its command in the parse and scale stages
// the speed by full scale product is registered before the divide by 255
// reset clears the line state and sets full scale to 500
// a stalled output holds the command; the pipeline keeps filling its empty
// stages and in_ready drops only when every stage is occupied
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ascii_motor_command_parser #(
    parameter int LINE_BYTES = amcp_pkg::LINE_BYTES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [7:0]                        rx_byte,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        command_kind,
    output logic                              motor_select,
    output logic                              forward,
    output logic [7:0]                        speed_level,
    output logic signed [amcp_pkg::VEL_W-1:0] velocity,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [amcp_pkg::ADDR_W-1:0]       paddr,
    input  logic [amcp_pkg::DATA_W-1:0]       pwdata,
    output logic [amcp_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);
    import amcp_pkg::*;

    logic [FSV_W-1:0]  fsv_reg, fsv_next;
    logic [ADDR_W-3:0] reg_index;

    logic              v1_reg, v1_next;
    logic [7:0]        byte_reg;
    logic              v2_reg, v2_next;
    cmd_t              cmd2_reg;
    logic [PROD_W-1:0] prod2_reg;
    logic              v3_reg, v3_next;
    cmd_t              cmd3_reg;
    logic signed [VEL_W-1:0] vel3_reg;

    logic              adv1, adv2, adv3;
    logic              emit;
    cmd_t              cmd;
    logic signed [VEL_W-1:0] vel_calc;

    // configuration port
    assign pready    = 1'b1;
    assign reg_index = paddr[ADDR_W-1:2];
    assign prdata    = (reg_index == REG_FULL_SCALE) ? DATA_W'(fsv_reg) : '0;

    always_comb
    begin
        fsv_next = fsv_reg;
        if (psel && penable && pwrite && (reg_index == REG_FULL_SCALE))
        begin
            fsv_next = pwdata[FSV_W-1:0];
        end
    end

    // pipeline flow control
    assign adv3     = !v3_reg || out_ready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    assign v1_next = adv1 ? in_valid : v1_reg;
    assign v2_next = adv2 ? (v1_reg && emit) : v2_reg;
    assign v3_next = adv3 ? v2_reg : v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsv_reg <= FSV_RESET;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
        end
        else
        begin
            fsv_reg <= fsv_next;
            v1_reg  <= v1_next;
            v2_reg  <= v2_next;
            v3_reg  <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
        end
        if (adv2)
        begin
            cmd2_reg  <= cmd;
            prod2_reg <= PROD_W'(cmd.speed) * PROD_W'(fsv_reg);
        end
        if (adv3)
        begin
            cmd3_reg <= cmd2_reg;
            vel3_reg <= vel_calc;
        end
    end

    amcp_parser #(
        .LINE_BYTES (LINE_BYTES)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .strobe  (v1_reg && adv2),
        .rx_byte (byte_reg),
        .emit    (emit),
        .cmd     (cmd)
    );

    amcp_scale u_scale (
        .cmd      (cmd2_reg),
        .product  (prod2_reg),
        .velocity (vel_calc)
    );

    assign out_valid    = v3_reg;
    assign command_kind = cmd3_reg.kind;
    assign motor_select = cmd3_reg.motor;
    assign forward      = cmd3_reg.fwd;
    assign speed_level  = cmd3_reg.speed;
    assign velocity     = vel3_reg;

    `ASSERT_IMPLIES(a_kind_valid, clk, rst_n, out_valid, command_kind != KIND_NONE)
    `ASSERT_IMPLIES(a_plain_zero, clk, rst_n,
        out_valid && (command_kind != KIND_MOTOR),
        !motor_select && !forward && (speed_level == 8'd0) && (velocity == '0))
    `ASSERT_IMPLIES(a_fwd_sign, clk, rst_n,
        out_valid && (command_kind == KIND_MOTOR) && forward, !velocity[VEL_W-1])
    `ASSERT_NEXT(a_stage_move, clk, rst_n, v2_reg && !v3_reg, out_valid)

endmodule
